[hw/rtl/bam_pkg.sv]
// Shared constants, types and weight tables for the Braitenberg avoid motor mixer.
// Used by every module in hw/rtl; depends on nothing else.

package bam_pkg;

  localparam int SENSOR_COUNT = 8;          // readings that contribute to the reflex
  localparam int PROX_FIELDS  = 8;          // reading fields carried in every item
  localparam int PROX_W       = 12;
  localparam int WEIGHT_W     = 4;
  localparam int TERM_W       = 16;         // reading times a weight of at most five
  localparam int SUM_W        = 18;
  localparam int REFL_W       = 15;
  localparam int MIX_W        = 18;
  localparam int SPEED_W      = 16;
  localparam int LIM_W        = 15;
  localparam int BIAS_W       = 12;
  localparam int HOLD_W       = 16;
  localparam int THR_W        = 16;
  localparam int MODE_W       = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int DEN_W        = 17;
  localparam int PROD_W       = 33;
  localparam int QUO_W        = 16;
  localparam int STEP_W       = 4;

  localparam int GROUP_LEFT_LSB  = PROX_FIELDS * PROX_W;
  localparam int GROUP_RIGHT_LSB = GROUP_LEFT_LSB + SPEED_W;
  localparam int IN_DATA_W       = GROUP_RIGHT_LSB + SPEED_W;
  localparam int OUT_DATA_W      = 2 * SPEED_W;

  // ceil(2^20 / 5): exact quotient by five for magnitudes below 2^18
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP5 = 18'd209716;

  // weights in tenths, sensor 0 first
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_LEFT [PROX_FIELDS] =
    '{4'sd5, 4'sd4, 4'sd3, 4'sd1, -4'sd1, -4'sd3, -4'sd4, -4'sd5};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_RIGHT [PROX_FIELDS] =
    '{-4'sd5, -4'sd4, -4'sd3, -4'sd1, 4'sd1, 4'sd3, 4'sd4, 4'sd5};

  localparam logic [LIM_W-1:0]  SPEED_LIMIT_RST = 15'd1000;
  localparam logic [BIAS_W-1:0] FWD_BIAS_RST    = 12'd200;
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST  = 16'd16;
  localparam logic [THR_W-1:0]  THRESHOLD_RST   = 16'd350;
  localparam logic [MODE_W-1:0] MODE_FLOCK      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PASS       = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SPEED_LIMIT = 3'd0,
    REG_FWD_BIAS    = 3'd1,
    REG_HOLD_TICKS  = 3'd2,
    REG_THRESHOLD   = 3'd3,
    REG_TASK_MODE   = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_REFLEX,
    ST_MIX,
    ST_MULT,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;   // form product and divisor
    logic step;   // one quotient bit
  } wheel_ctrl_t;

endpackage

[hw/rtl/bam_sensor_lane.sv]
// One sensor lane: weighted left and right terms of a single proximity reading.
// Depends on bam_pkg.

module bam_sensor_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [bam_pkg::PROX_W-1:0]           prox,
  input  logic signed [bam_pkg::WEIGHT_W-1:0]  weight_left,
  input  logic signed [bam_pkg::WEIGHT_W-1:0]  weight_right,
  output logic signed [bam_pkg::TERM_W-1:0]    term_left,
  output logic signed [bam_pkg::TERM_W-1:0]    term_right
);
  import bam_pkg::*;

  logic signed [PROX_W:0]          prox_s;
  logic signed [PROX_W+WEIGHT_W:0] prod_left;
  logic signed [PROX_W+WEIGHT_W:0] prod_right;

  assign prox_s     = $signed({1'b0, prox});
  assign prod_left  = prox_s * weight_left;
  assign prod_right = prox_s * weight_right;

  always_ff @(posedge clk) begin
    if (en) begin
      term_left  <= $signed(prod_left[TERM_W-1:0]);
      term_right <= $signed(prod_right[TERM_W-1:0]);
    end
  end

endmodule

[hw/rtl/bam_reflex_merge.sv]
// Merging stage: sums the lane terms per wheel, then forms the reflex -sum/5.
// Depends on bam_pkg.

module bam_reflex_merge (
  input  logic                               clk,
  input  logic                               sum_en,
  input  logic                               div_en,
  input  logic signed [bam_pkg::TERM_W-1:0]  terms_left  [bam_pkg::SENSOR_COUNT],
  input  logic signed [bam_pkg::TERM_W-1:0]  terms_right [bam_pkg::SENSOR_COUNT],
  output logic signed [bam_pkg::REFL_W-1:0]  refl_left,
  output logic signed [bam_pkg::REFL_W-1:0]  refl_right
);
  import bam_pkg::*;

  logic signed [SUM_W-1:0] sum_left;
  logic signed [SUM_W-1:0] sum_right;
  logic signed [SUM_W-1:0] sum_left_next;
  logic signed [SUM_W-1:0] sum_right_next;

  // truncate toward zero, sign flipped
  function automatic logic signed [REFL_W-1:0] reflex_of(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0]         mag;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [REFL_W-1:0]        q;
    mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    prod = mag * RECIP5;
    q    = prod[RECIP_SHIFT +: REFL_W];
    reflex_of = s[SUM_W-1] ? $signed(q) : -$signed(q);
  endfunction

  always_comb begin
    sum_left_next  = '0;
    sum_right_next = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      sum_left_next  = sum_left_next + SUM_W'(terms_left[i]);
      sum_right_next = sum_right_next + SUM_W'(terms_right[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_left  <= sum_left_next;
      sum_right <= sum_right_next;
    end
    if (div_en) begin
      refl_left  <= reflex_of(sum_left);
      refl_right <= reflex_of(sum_right);
    end
  end

endmodule

[hw/rtl/bam_wheel_scale.sv]
// One wheel: proportional rescale by a bit-serial restoring divider if peak > limit, then clamp.
// Depends on bam_pkg.

module bam_wheel_scale (
  input  logic                               clk,
  input  bam_pkg::wheel_ctrl_t               ctrl,
  input  logic signed [bam_pkg::MIX_W-1:0]   x,
  input  logic signed [bam_pkg::MIX_W-1:0]   peak,
  input  logic [bam_pkg::LIM_W-1:0]          lim,
  output logic signed [bam_pkg::SPEED_W-1:0] speed
);
  import bam_pkg::*;

  logic signed [MIX_W:0]        lim_s;
  logic signed [MIX_W:0]        shifted;
  logic signed [MIX_W:0]        den_full;
  logic [DEN_W-1:0]             mag;
  logic [SPEED_W-1:0]           two_lim;
  logic [PROD_W-1:0]            prod_next;
  logic [PROD_W-1:0]            rem;
  logic [DEN_W+QUO_W-2:0]       dsh;
  logic [QUO_W-1:0]             quo;
  logic                         neg;
  logic                         scale;
  logic signed [MIX_W:0]        quo_s;
  logic signed [MIX_W:0]        floor_q;
  logic signed [MIX_W:0]        scaled;
  logic signed [MIX_W:0]        pick;
  logic signed [MIX_W:0]        clamped;
  logic                         fits;

  assign lim_s     = $signed({{(MIX_W+1-LIM_W){1'b0}}, lim});
  assign shifted   = (MIX_W+1)'(x) + lim_s;
  assign den_full  = (MIX_W+1)'(peak) + lim_s;
  assign mag       = shifted[MIX_W] ? DEN_W'(-shifted) : DEN_W'(shifted);
  assign two_lim   = {lim, 1'b0};
  assign prod_next = mag * two_lim;
  assign fits      = rem >= PROD_W'(dsh);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem   <= prod_next;
      dsh   <= {den_full[DEN_W-1:0], {(QUO_W-1){1'b0}}};
      quo   <= '0;
      neg   <= shifted[MIX_W];
      scale <= peak > lim_s;
    end else if (ctrl.step) begin
      if (fits) begin
        rem <= rem - PROD_W'(dsh);
      end
      quo <= {quo[QUO_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  // floor of a negative quotient rounds the magnitude up
  always_comb begin
    quo_s   = $signed({{(MIX_W+1-QUO_W){1'b0}}, quo});
    floor_q = neg ? -(quo_s + $signed({{MIX_W{1'b0}}, rem != '0})) : quo_s;
    scaled  = floor_q - lim_s;
    pick    = scale ? scaled : (MIX_W+1)'(x);
    if (pick > lim_s) begin
      clamped = lim_s;
    end else if (pick < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = pick;
    end
    speed = $signed(clamped[SPEED_W-1:0]);
  end

endmodule

[hw/rtl/braitenberg_avoid_motor_mix_unit.sv]
// Braitenberg avoid motor mixer: one item per control tick, one result item per input item.
// Depends on bam_pkg, bam_sensor_lane, bam_reflex_merge and bam_wheel_scale.
//
// An item passes through the sensor lanes, the merge stage, the mix and hold update and the wheel
// dividers; the result is registered at the output once that register is free, and the next
// item is accepted only after that. Eight sensor lanes register the weighted terms, the merge
// stage registers the sums and then the division by five, the mix and hold update follows, and
// the two wheel dividers run side by side and retire one quotient bit a cycle. A finished result
// waits in the output register without holding up acceptance of the next item. Configuration
// writes take effect at once and are meant for when the block is idle.

module braitenberg_avoid_motor_mix_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // prox_0 .. prox_7 (12 bits each), group_left, group_right
  input  logic [bam_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // left_speed, right_speed
  output logic [bam_pkg::OUT_DATA_W-1:0]      m_tdata,
  // avoiding
  output logic                                m_tuser,
  input  logic                                cfg_we,
  input  logic [bam_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bam_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bam_pkg::*;

  state_t state, state_next;

  logic [LIM_W-1:0]  speed_limit;
  logic [BIAS_W-1:0] fwd_bias;
  logic [HOLD_W-1:0] avoid_hold_ticks;
  logic [THR_W-1:0]  avoid_threshold;
  logic [MODE_W-1:0] task_mode;

  logic [HOLD_W-1:0] hold_remaining;
  logic [HOLD_W-1:0] hold_remaining_next;
  logic [STEP_W-1:0] step_cnt;

  logic signed [SPEED_W-1:0] group_left;
  logic signed [SPEED_W-1:0] group_right;

  logic signed [TERM_W-1:0] term_left  [SENSOR_COUNT];
  logic signed [TERM_W-1:0] term_right [SENSOR_COUNT];
  logic signed [REFL_W-1:0] refl_left;
  logic signed [REFL_W-1:0] refl_right;

  logic signed [MIX_W-1:0] mix_left, mix_left_next;
  logic signed [MIX_W-1:0] mix_right, mix_right_next;
  logic signed [MIX_W-1:0] peak;
  logic                    avoid_q, avoid_next;

  logic [REFL_W-2:0] abs_left;
  logic [REFL_W-2:0] abs_right;
  logic [REFL_W-1:0] abs_sum;
  logic              trigger;

  logic signed [SPEED_W-1:0] speed_left;
  logic signed [SPEED_W-1:0] speed_right;

  logic        accept;
  logic        sum_en;
  logic        refl_en;
  logic        mix_en;
  logic        fin_load;
  logic        out_free;
  wheel_ctrl_t wheel_ctrl;

  assign out_free = !m_tvalid || m_tready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SUM;
      ST_SUM:    state_next = ST_REFLEX;
      ST_REFLEX: state_next = ST_MIX;
      ST_MIX:    state_next = ST_MULT;
      ST_MULT:   state_next = ST_DIV;
      ST_DIV:    if (step_cnt == '0) state_next = ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    sum_en          = 1'b0;
    refl_en         = 1'b0;
    mix_en          = 1'b0;
    wheel_ctrl.load = 1'b0;
    wheel_ctrl.step = 1'b0;
    fin_load        = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_SUM:    sum_en = 1'b1;
      ST_REFLEX: refl_en = 1'b1;
      ST_MIX:    mix_en = 1'b1;
      ST_MULT:   wheel_ctrl.load = 1'b1;
      ST_DIV:    wheel_ctrl.step = 1'b1;
      ST_FIN:    fin_load = out_free;
      default:   s_tready = 1'b0;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (wheel_ctrl.load) begin
        step_cnt <= STEP_W'(QUO_W - 1);
      end else if (wheel_ctrl.step) begin
        step_cnt <= step_cnt - 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit      <= SPEED_LIMIT_RST;
      fwd_bias         <= FWD_BIAS_RST;
      avoid_hold_ticks <= HOLD_TICKS_RST;
      avoid_threshold  <= THRESHOLD_RST;
      task_mode        <= MODE_FLOCK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_LIMIT: speed_limit      <= cfg_data[LIM_W-1:0];
        REG_FWD_BIAS:    fwd_bias         <= cfg_data[BIAS_W-1:0];
        REG_HOLD_TICKS:  avoid_hold_ticks <= cfg_data[HOLD_W-1:0];
        REG_THRESHOLD:   avoid_threshold  <= cfg_data[THR_W-1:0];
        REG_TASK_MODE:   task_mode        <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sensor lanes
  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    bam_sensor_lane u_lane (
      .clk          (clk),
      .en           (accept),
      .prox         (s_tdata[i*PROX_W +: PROX_W]),
      .weight_left  (WEIGHT_LEFT[i]),
      .weight_right (WEIGHT_RIGHT[i]),
      .term_left    (term_left[i]),
      .term_right   (term_right[i])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      group_left  <= $signed(s_tdata[GROUP_LEFT_LSB +: SPEED_W]);
      group_right <= $signed(s_tdata[GROUP_RIGHT_LSB +: SPEED_W]);
    end
  end

  bam_reflex_merge u_merge (
    .clk         (clk),
    .sum_en      (sum_en),
    .div_en      (refl_en),
    .terms_left  (term_left),
    .terms_right (term_right),
    .refl_left   (refl_left),
    .refl_right  (refl_right)
  );

  // ---------------------------------------------------------------- avoid decision and mix
  always_comb begin
    abs_left  = refl_left[REFL_W-1] ? (REFL_W-1)'(-refl_left) : refl_left[REFL_W-2:0];
    abs_right = refl_right[REFL_W-1] ? (REFL_W-1)'(-refl_right) : refl_right[REFL_W-2:0];
    abs_sum   = REFL_W'(abs_left) + REFL_W'(abs_right);
    trigger   = THR_W'(abs_sum) > avoid_threshold;

    hold_remaining_next = hold_remaining;
    avoid_next          = 1'b0;
    if (hold_remaining != '0) begin
      avoid_next          = 1'b1;
      hold_remaining_next = hold_remaining - 1'b1;
    end else if (trigger) begin
      avoid_next          = 1'b1;
      hold_remaining_next = (avoid_hold_ticks != '0) ? avoid_hold_ticks - 1'b1 : '0;
    end

    if (avoid_next) begin
      mix_left_next  = MIX_W'(refl_left) + $signed(MIX_W'(fwd_bias));
      mix_right_next = MIX_W'(refl_right) + $signed(MIX_W'(fwd_bias));
    end else if (task_mode == MODE_PASS) begin
      mix_left_next  = MIX_W'(group_left);
      mix_right_next = MIX_W'(group_right);
    end else begin
      mix_left_next  = MIX_W'(group_left) + MIX_W'(refl_left)
                       + $signed(MIX_W'(fwd_bias[BIAS_W-1:2]));
      mix_right_next = MIX_W'(group_right) + MIX_W'(refl_right)
                       + $signed(MIX_W'(fwd_bias[BIAS_W-1:2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_remaining <= '0;
    end else if (mix_en) begin
      hold_remaining <= hold_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_en) begin
      mix_left  <= mix_left_next;
      mix_right <= mix_right_next;
      avoid_q   <= avoid_next;
    end
  end

  assign peak = (mix_left > mix_right) ? mix_left : mix_right;

  // ---------------------------------------------------------------- wheel units
  bam_wheel_scale u_wheel_left (
    .clk   (clk),
    .ctrl  (wheel_ctrl),
    .x     (mix_left),
    .peak  (peak),
    .lim   (speed_limit),
    .speed (speed_left)
  );

  bam_wheel_scale u_wheel_right (
    .clk   (clk),
    .ctrl  (wheel_ctrl),
    .x     (mix_right),
    .peak  (peak),
    .lim   (speed_limit),
    .speed (speed_right)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      m_tdata <= {speed_right, speed_left};
      m_tuser <= avoid_q;
    end
  end

  // ---------------------------------------------------------------- checks
  a_hold_counts_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIX && hold_remaining != '0)
      |=> (avoid_q && hold_remaining == $past(hold_remaining) - 1'b1))
    else $error("running hold did not force avoidance and count down");

  a_divider_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step_cnt == '0) |=> state == ST_FIN)
    else $error("divider did not finish after its last quotient bit");

  a_result_flag: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> (m_tvalid && m_tuser == $past(avoid_q)))
    else $error("result item lost its avoid flag");

endmodule
